/* rtl/bounded_unsorted_set_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bounded unsorted set
// Shared property wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNSORTED_SET_ASSERT_SVH
`define BOUNDED_UNSORTED_SET_ASSERT_SVH

// same-cycle implication
`define BUS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BUS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bus_pkg.sv */
// ----------------------------------------------------------------------------
// bus_pkg
// Command codes and fixed field widths of the bounded unsorted set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bus_pkg;

	localparam int CMD_W       = 2;
	localparam int ELEM_IN_W   = 32;
	localparam int COUNT_OUT_W = 7;

	typedef logic [CMD_W-1:0]        cmd_t;
	typedef logic signed [ELEM_IN_W-1:0] elem_in_t;
	typedef logic [COUNT_OUT_W-1:0]  count_out_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_DELETE = 2'd1;
	localparam cmd_t CMD_QUERY  = 2'd2;

endpackage

/* rtl/bus_in_if.sv */
// ----------------------------------------------------------------------------
// bus_in_if
// Command channel: valid/ready handshake carrying a command and an element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bus_in_if;
	import bus_pkg::*;

	logic     valid;
	logic     ready;
	cmd_t     command;
	elem_in_t element;

	modport source (output valid, output command, output element, input ready);
	modport sink (input valid, input command, input element, output ready);
endinterface

/* rtl/bus_out_if.sv */
// ----------------------------------------------------------------------------
// bus_out_if
// Result channel: valid/ready handshake carrying membership and count status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bus_out_if;
	import bus_pkg::*;

	logic       valid;
	logic       ready;
	logic       found;
	count_out_t member_count;
	logic       is_empty;
	logic       is_full;
	logic       rejected;

	modport source (
		output valid, output found, output member_count, output is_empty,
		output is_full, output rejected, input ready
	);
	modport sink (
		input valid, input found, input member_count, input is_empty,
		input is_full, input rejected, output ready
	);
endinterface

/* rtl/bounded_unsorted_set.sv */
// Sequence: after the command beat the sequencer scans the stored entries (ST_SCAN),
// acts (ST_ACT), does the delete move (ST_MOVE) and loads the result (ST_RESP).
// Any hit ends the scan at that entry; only a delete of a hit takes the move state.
// Commands: one at a time; the shared comparator scan serves each command in turn,
// and a new command is accepted only once its result is loaded.
// Reset: arst_n clears the count and the sequencer; memory contents are kept.
// ----------------------------------------------------------------------------
// bounded_unsorted_set
// Unsorted set of up to CAPACITY elements with insert, delete and query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_unsorted_set #(
	parameter int CAPACITY   = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	bus_in_if.sink    req,
	bus_out_if.source rsp
);
	import bus_pkg::*;

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_MOVE,
		ST_RESP
	} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [ELEM_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic [AW-1:0]         slot_q;
	logic                  found_q;
	logic                  rejected_q;
	logic                  rsp_valid_q;
	logic                  rsp_found_q;
	logic [CNT_W-1:0]      rsp_count_q;
	logic                  rsp_empty_q;
	logic                  rsp_full_q;
	logic                  rsp_rejected_q;

	logic [ELEM_WIDTH-1:0] key_in;
	logic [ELEM_WIDTH-1:0] rd_data;
	logic                  match;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [ELEM_WIDTH-1:0] wr_data;
	logic [AW-1:0]         rd_addr;
	logic [CNT_W-1:0]      idx_next;
	logic [CNT_W-1:0]      cnt_m1;
	logic                  is_ins;
	logic                  is_del;
	logic                  full;
	logic                  ins_write;

	if (ELEM_WIDTH <= ELEM_IN_W) begin : g_key_trunc
		assign key_in = req.element[ELEM_WIDTH-1:0];
	end else begin : g_key_ext
		assign key_in = {{(ELEM_WIDTH-ELEM_IN_W){req.element[ELEM_IN_W-1]}}, req.element};
	end

	if (CNT_W >= COUNT_OUT_W) begin : g_cnt_trunc
		assign rsp.member_count = rsp_count_q[COUNT_OUT_W-1:0];
	end else begin : g_cnt_ext
		assign rsp.member_count = {{(COUNT_OUT_W-CNT_W){1'b0}}, rsp_count_q};
	end

	assign idx_next  = idx_q + ONE_CNT;
	assign cnt_m1    = count_q - ONE_CNT;
	assign is_ins    = (cmd_q == CMD_INSERT);
	assign is_del    = (cmd_q == CMD_DELETE);
	assign full      = (count_q == CAP_CNT);
	assign ins_write = (state_q == ST_ACT) && is_ins && !found_q && !full;

	always_comb begin
		unique case (state_q)
			ST_SCAN: rd_addr = idx_next[AW-1:0];
			ST_ACT:  rd_addr = cnt_m1[AW-1:0];
			default: rd_addr = '0;
		endcase
	end

	assign wr_en   = ins_write || (state_q == ST_MOVE);
	assign wr_addr = (state_q == ST_MOVE) ? slot_q : count_q[AW-1:0];
	assign wr_data = (state_q == ST_MOVE) ? rd_data : key_q;

	bus_store #(
		.DEPTH (CAPACITY),
		.WIDTH (ELEM_WIDTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.key     (key_q),
		.rd_data (rd_data),
		.match   (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cmd_q          <= CMD_QUERY;
			key_q          <= '0;
			count_q        <= '0;
			idx_q          <= '0;
			slot_q         <= '0;
			found_q        <= 1'b0;
			rejected_q     <= 1'b0;
			rsp_valid_q    <= 1'b0;
			rsp_found_q    <= 1'b0;
			rsp_count_q    <= '0;
			rsp_empty_q    <= 1'b1;
			rsp_full_q     <= 1'b0;
			rsp_rejected_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && (state_q != ST_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q      <= req.command;
						key_q      <= key_in;
						idx_q      <= '0;
						found_q    <= 1'b0;
						rejected_q <= 1'b0;
						state_q    <= (count_q == '0) ? ST_ACT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						found_q <= 1'b1;
						slot_q  <= idx_q[AW-1:0];
						state_q <= ST_ACT;
					end else if (idx_next == count_q) begin
						state_q <= ST_ACT;
					end else begin
						idx_q <= idx_next;
					end
				end
				ST_ACT: begin
					state_q <= ST_RESP;
					if (is_ins && !found_q) begin
						if (full) begin
							rejected_q <= 1'b1;
						end else begin
							count_q <= count_q + ONE_CNT;
						end
					end else if (is_del && found_q) begin
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					count_q <= cnt_m1;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q    <= 1'b1;
						rsp_found_q    <= found_q;
						rsp_count_q    <= count_q;
						rsp_empty_q    <= (count_q == '0);
						rsp_full_q     <= full;
						rsp_rejected_q <= rejected_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready    = (state_q == ST_IDLE);
	assign rsp.valid    = rsp_valid_q;
	assign rsp.found    = rsp_found_q;
	assign rsp.is_empty = rsp_empty_q;
	assign rsp.is_full  = rsp_full_q;
	assign rsp.rejected = rsp_rejected_q;

`include "bounded_unsorted_set_assert.svh"

	`BUS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_CNT, "count exceeds capacity")
	`BUS_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_q != ST_IDLE, "no busy after beat")
	`BUS_ASSERT_NOW(a_move_found, state_q == ST_MOVE, found_q && count_q != '0, "bad delete move")
	`BUS_ASSERT_NOW(a_rsp_from_resp, $rose(rsp_valid_q), $past(state_q == ST_RESP), "stray result")

endmodule

/* rtl/bus_store.sv */
// ----------------------------------------------------------------------------
// bus_store
// Element memory with one write port, one registered read port and the
// shared equality comparator used by the scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bus_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	input  logic [WIDTH-1:0] key,
	output logic [WIDTH-1:0] rd_data,
	output logic             match
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign match   = (rd_data_q == key);

endmodule
